FILE: design/cts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg
// Shared widths, codes and controller/datapath interface types for the
// CDF table sampler.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int MAX_ENTRIES_DEF = 256;

    localparam int WEIGHT_W = 16;
    localparam int RAND_W   = 17;
    localparam int SUM_W    = 24;
    localparam int INDEX_W  = 8;
    localparam int CFG_W    = 9;
    localparam int TGT_W    = RAND_W + SUM_W;
    localparam int SDATA_W  = ((WEIGHT_W + RAND_W + 7) / 8) * 8;
    localparam int MDATA_W  = ((INDEX_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0]  TABLE_SIZE_RST = CFG_W'(256);
    localparam logic [RAND_W-1:0] ONE_Q16        = RAND_W'(65536);

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic load_exec;
        logic search_init;
        logic search_cmp;
        logic out_load;
    } cts_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic zero_total;
        logic search_last;
    } cts_sts_t;

endpackage

FILE: design/cdf_table_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdf_table_sampler
// Discrete-distribution sampler: loads weights into a prefix-sum table and
// draws entries by binary search against a scaled uniform value.
// ----------------------------------------------------------------------------
// After reset the table is zeroed by a clearing pass over every entry, during
// which s_axis_tready stays low (table_size writes are still taken).
// One transfer is worked at a time, and every input transfer gives exactly one
// output transfer. A load is captured, written to the table and then handed to
// the output register. A sample is captured, its bounds and target are set up
// and k search steps follow, k being at most clog2(n)+1 for n entries in use;
// each step is one registered read of the prefix-sum memory (separate write
// port) and one compare. A zero total skips the search. A new transfer is
// accepted while a finished result still waits in the output register.
module cdf_table_sampler #(
    parameter int MAX_ENTRIES = cts_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cts_pkg::CFG_W-1:0]     cfg_wr_data,   // table_size
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cts_pkg::SDATA_W-1:0]   s_axis_tdata,  // weight, random_value
    input  logic                          s_axis_tuser,  // req_type
    input  logic                          s_axis_tlast,  // last_weight
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [cts_pkg::MDATA_W-1:0]   m_axis_tdata,  // sample_index
    output logic                          m_axis_tuser   // status
);
    import cts_pkg::*;

    cts_cmd_t           cmd;
    cts_sts_t           sts;
    logic [INDEX_W-1:0] out_index;

    cts_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    cts_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_req_type (s_axis_tuser),
        .in_last     (s_axis_tlast),
        .in_weight   (s_axis_tdata[WEIGHT_W-1:0]),
        .in_random   (s_axis_tdata[WEIGHT_W+RAND_W-1:WEIGHT_W]),
        .cmd         (cmd),
        .sts         (sts),
        .out_index   (out_index),
        .out_status  (m_axis_tuser)
    );

    assign m_axis_tdata = MDATA_W'(out_index);

endmodule

FILE: design/cts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_ctrl
// Sequencer for table clearing, weight loads, binary search and result
// hand-off to the output register.
// ----------------------------------------------------------------------------
module cts_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tuser,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  cts_pkg::cts_sts_t sts,
    output cts_pkg::cts_cmd_t cmd
);
    import cts_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_INIT,
        ST_ADDR,
        ST_CMP,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = (s_axis_tuser == REQ_SAMPLE) ? ST_INIT : ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load_exec = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_INIT: begin
                cmd.search_init = 1'b1;
                state_next      = sts.zero_total ? ST_RESULT : ST_ADDR;
            end
            ST_ADDR: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.search_cmp = 1'b1;
                state_next     = sts.search_last ? ST_RESULT : ST_ADDR;
            end
            ST_RESULT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_axis_tready))
        else $error("result loaded over an untaken transfer");

    a_valid_from_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("output valid raised outside result state");

endmodule

FILE: design/cts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_dp
// Datapath: prefix-sum table memory, load accumulator, search bounds and
// the output register.
// ----------------------------------------------------------------------------
module cts_dp #(
    parameter int MAX_ENTRIES = cts_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cts_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          in_req_type,
    input  logic                          in_last,
    input  logic [cts_pkg::WEIGHT_W-1:0]  in_weight,
    input  logic [cts_pkg::RAND_W-1:0]    in_random,
    input  cts_pkg::cts_cmd_t             cmd,
    output cts_pkg::cts_sts_t             sts,
    output logic [cts_pkg::INDEX_W-1:0]   out_index,
    output logic                          out_status
);
    import cts_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = $clog2(MAX_ENTRIES + 2);

    logic [SUM_W-1:0]   prefix_mem [MAX_ENTRIES];
    logic [SUM_W-1:0]   rd_data_reg;

    logic [CFG_W-1:0]   table_size_reg, table_size_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [PW-1:0]      load_ptr_reg, load_ptr_next;
    logic [SUM_W-1:0]   running_sum_reg, running_sum_next;
    logic [SUM_W-1:0]   weight_total_reg, weight_total_next;

    logic               req_reg;
    logic               last_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [RAND_W-1:0]  random_reg;
    logic               load_status_reg, load_status_next;
    logic [TGT_W-1:0]   target_reg;
    logic [NW-1:0]      left_reg, left_next;
    logic [NW-1:0]      right_reg, right_next;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_status_reg;

    logic [NW-1:0]      n_eff;
    logic [NW:0]        bound_sum;
    logic [NW-1:0]      mid;
    logic [RAND_W-1:0]  r_clamp;
    logic [SUM_W:0]     sum_ext;
    logic [SUM_W-1:0]   sum_sat;
    logic [PW-1:0]      ptr_inc;
    logic               ptr_in_table;
    logic               below;
    logic [NW-1:0]      result_idx;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [SUM_W-1:0]   mem_wdata;

    // effective size, clamped to 1..MAX_ENTRIES
    always_comb begin
        if (table_size_reg == '0) begin
            n_eff = NW'(1);
        end else if (32'(table_size_reg) > 32'(MAX_ENTRIES)) begin
            n_eff = NW'(MAX_ENTRIES);
        end else begin
            n_eff = NW'(table_size_reg);
        end
    end

    assign bound_sum = {1'b0, left_reg} + {1'b0, right_reg};
    assign mid       = bound_sum[NW:1];
    assign r_clamp   = (random_reg > ONE_Q16) ? ONE_Q16 : random_reg;

    assign sum_ext      = {1'b0, running_sum_reg} + (SUM_W + 1)'(weight_reg);
    assign sum_sat      = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    assign ptr_in_table = 32'(load_ptr_reg) < 32'(MAX_ENTRIES);
    assign ptr_inc      = (32'(load_ptr_reg) <= 32'(MAX_ENTRIES)) ? load_ptr_reg + PW'(1)
                                                                  : load_ptr_reg;

    // prefix*2^16 < r*total
    assign below = {1'b0, rd_data_reg, 16'b0} < target_reg;

    assign result_idx = (left_reg < n_eff) ? left_reg : n_eff - NW'(1);

    assign mem_we    = cmd.clear_step || (cmd.load_exec && ptr_in_table);
    assign mem_waddr = cmd.clear_step ? clr_cnt_reg : load_ptr_reg[AW-1:0];
    assign mem_wdata = cmd.clear_step ? '0 : sum_sat;

    always_comb begin
        table_size_next   = cfg_wr_en ? cfg_wr_data : table_size_reg;
        clr_cnt_next      = cmd.clear_step ? clr_cnt_reg + AW'(1) : clr_cnt_reg;
        load_ptr_next     = load_ptr_reg;
        running_sum_next  = running_sum_reg;
        weight_total_next = weight_total_reg;
        load_status_next  = load_status_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        if (cmd.load_exec) begin
            if (last_reg) begin
                weight_total_next = sum_sat;
                load_status_next  = (32'(ptr_inc) != 32'(n_eff));
                load_ptr_next     = '0;
                running_sum_next  = '0;
            end else begin
                load_status_next  = 1'b0;
                load_ptr_next     = ptr_inc;
                running_sum_next  = sum_sat;
            end
        end
        if (cmd.search_init) begin
            if (weight_total_reg == '0) begin
                left_next  = (r_clamp == '0) ? '0 : n_eff - NW'(1);
                right_next = left_next;
            end else begin
                left_next  = '0;
                right_next = n_eff;
            end
        end else if (cmd.search_cmp) begin
            if (below) begin
                left_next = mid + NW'(1);
            end else begin
                right_next = mid;
            end
        end
    end

    assign sts.clear_done  = (clr_cnt_reg == AW'(MAX_ENTRIES - 1));
    assign sts.zero_total  = (weight_total_reg == '0);
    assign sts.search_last = (left_next == right_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg   <= TABLE_SIZE_RST;
            clr_cnt_reg      <= '0;
            load_ptr_reg     <= '0;
            running_sum_reg  <= '0;
            weight_total_reg <= '0;
        end else begin
            table_size_reg   <= table_size_next;
            clr_cnt_reg      <= clr_cnt_next;
            load_ptr_reg     <= load_ptr_next;
            running_sum_reg  <= running_sum_next;
            weight_total_reg <= weight_total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg    <= in_req_type;
            last_reg   <= in_last;
            weight_reg <= in_weight;
            random_reg <= in_random;
        end
        if (cmd.search_init) begin
            target_reg <= TGT_W'(r_clamp) * TGT_W'(weight_total_reg);
        end
        load_status_reg <= load_status_next;
        left_reg        <= left_next;
        right_reg       <= right_next;
        if (cmd.out_load) begin
            if (req_reg == REQ_SAMPLE) begin
                out_index_reg  <= INDEX_W'(result_idx);
                out_status_reg <= 1'b0;
            end else begin
                out_index_reg  <= '0;
                out_status_reg <= load_status_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            prefix_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= prefix_mem[mid[AW-1:0]];
    end

    assign out_index  = out_index_reg;
    assign out_status = out_status_reg;

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_exec && last_reg) |=> (load_ptr_reg == '0 && running_sum_reg == '0))
        else $error("last load did not restart the table");

    a_bounds_open: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.search_cmp |-> (left_reg < right_reg))
        else $error("search step on an empty interval");

    a_bounds_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.search_cmp |-> (right_reg <= n_eff))
        else $error("search bound beyond table size");

endmodule

FILE: sim/tb_cdf_table_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cdf_table_sampler
// Self-checking bench for the CDF table sampler. Streams weight loads and
// draws with random handshake gaps and output stalls, predicts every index and
// status in a scoreboard that keeps its own prefix-sum table, and compares
// each output transfer with the oldest prediction across a range of table
// sizes (the clamped extremes included).
// ----------------------------------------------------------------------------
module tb_cdf_table_sampler;
    import cts_pkg::*;

    localparam int ENTRIES  = MAX_ENTRIES_DEF;
    localparam int IDLE_PCT = 36;

    typedef struct {
        bit [INDEX_W-1:0] pick;
        bit               mismatch;
    } pick_t;

    // Tracks the prefix-sum table and the expected output transfers.
    class draw_tracker;
        bit [SUM_W-1:0]   cdf_mem [ENTRIES];
        int unsigned      fill_count;
        bit [SUM_W-1:0]   acc_sum;
        bit [SUM_W-1:0]   total;
        bit [CFG_W-1:0]   size_reg;
        pick_t            awaited_picks [$];
        int unsigned      errors;

        function new();
            foreach (cdf_mem[i]) cdf_mem[i] = '0;
            fill_count = 0;
            acc_sum    = '0;
            total      = '0;
            size_reg   = TABLE_SIZE_RST;
            errors     = 0;
        endfunction

        function void write_size(bit [CFG_W-1:0] v);
            size_reg = v;
        endfunction

        function int unsigned used_entries();
            int unsigned n;
            n = size_reg;
            if (n < 1) n = 1;
            if (n > ENTRIES) n = ENTRIES;
            return n;
        endfunction

        function int unsigned pending();
            return awaited_picks.size();
        endfunction

        function bit [INDEX_W-1:0] pick_entry(bit [RAND_W-1:0] rv);
            int unsigned n, lo, hi, mid;
            bit [RAND_W-1:0] r;
            bit [63:0] target, scaled;
            n = used_entries();
            r = (rv > ONE_Q16) ? ONE_Q16 : rv;
            if (total == '0)
                return (r == '0) ? '0 : INDEX_W'(n - 1);
            target = 64'(r) * 64'(total);
            lo = 0;
            hi = n;
            while (lo < hi) begin
                mid    = lo + (hi - lo) / 2;
                scaled = 64'(cdf_mem[mid]) << 16;
                if (scaled < target) lo = mid + 1;
                else hi = mid;
            end
            return INDEX_W'((lo < n) ? lo : n - 1);
        endfunction

        function void take_request(bit req, bit [WEIGHT_W-1:0] w, bit last,
                                   bit [RAND_W-1:0] rv);
            pick_t p;
            bit [SUM_W:0] s;
            p.pick     = '0;
            p.mismatch = 1'b0;
            if (req == REQ_SAMPLE) begin
                p.pick = pick_entry(rv);
            end else begin
                s       = {1'b0, acc_sum} + (SUM_W + 1)'(w);
                acc_sum = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
                if (fill_count < ENTRIES) cdf_mem[fill_count] = acc_sum;
                if (fill_count <= ENTRIES) fill_count++;
                if (last) begin
                    total      = acc_sum;
                    p.mismatch = (fill_count != used_entries());
                    fill_count = 0;
                    acc_sum    = '0;
                end
            end
            awaited_picks.push_back(p);
        endfunction

        function void match_result(bit [INDEX_W-1:0] idx, bit st);
            pick_t p;
            if (awaited_picks.size() == 0) begin
                $error("unexpected output transfer: sample_index %0d, status %0d", idx, st);
                errors++;
                return;
            end
            p = awaited_picks.pop_front();
            if (idx != p.pick) begin
                $error("sample_index: expected %0d, got %0d", p.pick, idx);
                errors++;
            end
            if (st != p.mismatch) begin
                $error("status: expected %0d, got %0d", p.mismatch, st);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [SDATA_W-1:0]   s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [MDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tuser;

    draw_tracker tracker;
    bit          steady     = 1'b0;
    int unsigned load_count = 0;
    int unsigned draw_count = 0;
    int unsigned size_count = 0;

    cdf_table_sampler u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            tracker.match_result(m_axis_tdata[INDEX_W-1:0], m_axis_tuser);
        end
    end

    task automatic send_item(bit req, bit [WEIGHT_W-1:0] w, bit last,
                             bit [RAND_W-1:0] rv);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= SDATA_W'({rv, w});
        s_axis_tuser  <= req;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        tracker.take_request(req, w, last, rv);
        if (req == REQ_SAMPLE) draw_count++;
        else load_count++;
    endtask

    task automatic load(bit [WEIGHT_W-1:0] w, bit last);
        send_item(REQ_LOAD, w, last, RAND_W'($urandom));
    endtask

    task automatic draw(bit [RAND_W-1:0] rv);
        send_item(REQ_SAMPLE, WEIGHT_W'($urandom), 1'($urandom), rv);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_table_size(bit [CFG_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.write_size(v);
        size_count++;
    endtask

    function automatic bit [RAND_W-1:0] random_draw();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 10) return '0;
        if (k < 20) return ONE_Q16;
        if (k < 30) return RAND_W'($urandom_range(131071, 65537));
        return RAND_W'($urandom_range(65536));
    endfunction

    function automatic bit [WEIGHT_W-1:0] random_weight(int unsigned style);
        case (style)
            0: return WEIGHT_W'($urandom);
            1: return ($urandom_range(9) == 0) ? WEIGHT_W'($urandom) : '0;
            2: return {WEIGHT_W{1'b1}};
            default: return WEIGHT_W'($urandom_range(3));
        endcase
    endfunction

    // Load a table of count weights (optionally leaving it open), with the
    // odd draw slipped in mid-load, then a run of draws.
    task automatic run_phase(bit [CFG_W-1:0] sz, int unsigned draws);
        int unsigned n, count, style, k;
        bit open;
        set_table_size(sz);
        n     = tracker.used_entries();
        count = n;
        k     = $urandom_range(99);
        if (k < 15 && n > 1) count = n - 1;
        else if (k < 30) count = n + $urandom_range(2, 1);
        open  = ($urandom_range(9) == 0);
        style = $urandom_range(3);
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0) draw(random_draw());
            load(random_weight(style), (i == count - 1) && !open);
        end
        repeat (draws) draw(random_draw());
    endtask

    initial begin
        tracker = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // zero total straight after reset
        draw('0);
        draw(RAND_W'(1));
        draw({RAND_W{1'b1}});

        // four equal weights: total of exactly one, boundaries hit exactly
        set_table_size(CFG_W'(4));
        repeat (3) load(WEIGHT_W'(16384), 1'b0);
        load(WEIGHT_W'(16384), 1'b1);
        draw(RAND_W'(16384));
        draw(RAND_W'(16385));
        draw('0);
        draw(RAND_W'(49152));
        draw(ONE_Q16);
        draw({RAND_W{1'b1}});

        // size 0 acts as one entry; a second weight is one too many
        set_table_size('0);
        load({WEIGHT_W{1'b1}}, 1'b1);
        draw(RAND_W'(40000));
        load(WEIGHT_W'(1), 1'b0);
        load(WEIGHT_W'(2), 1'b1);

        // short load of zero weights gives a zero total
        set_table_size(CFG_W'(3));
        load('0, 1'b0);
        load('0, 1'b1);
        draw('0);
        draw(RAND_W'(5));

        // oversized register, overlong load of full weights: sum saturates
        set_table_size({CFG_W{1'b1}});
        steady = 1'b1;
        for (int i = 0; i < ENTRIES + 2; i++) load({WEIGHT_W{1'b1}}, i == ENTRIES + 1);
        steady = 1'b0;
        repeat (12) draw(random_draw());

        // full size, short load: old entries stay in the search
        set_table_size(CFG_W'(ENTRIES));
        for (int i = 0; i < 5; i++) load(WEIGHT_W'($urandom), i == 4);
        repeat (10) draw(random_draw());

        run_phase(CFG_W'(1), 6);
        run_phase(CFG_W'(2), 8);
        run_phase(CFG_W'(7), 8);
        run_phase(CFG_W'(16), 8);
        run_phase(CFG_W'($urandom_range(40, 3)), 8);
        run_phase(CFG_W'($urandom_range(24, 1)), 8);
        run_phase(CFG_W'(5), 8);

        drain();
        repeat (60) @(posedge aclk);
        $display("Ran %0d weight loads and %0d draws over %0d table size settings,",
                 load_count, draw_count, size_count);
        $display("including zero totals, saturated sums and clamped sizes.");
        if (tracker.errors == 0) begin
            $display("cdf_table_sampler verification clean");
        end else begin
            $display("cdf_table_sampler verification failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Run timed out with %0d transfers outstanding", tracker.pending());
        $display("cdf_table_sampler verification failed");
        $finish;
    end

endmodule
